@@ sv/ppt_pkg.sv @@
package ppt_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_SIZE  = 1 << PAGE_SHIFT;
  localparam int PAGE_IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int PAGE_CNT_W = PAGE_IDX_W + 1;

  localparam int ADDR_W     = 64;
  localparam int LEN_W      = 23;
  localparam int SEG_W      = 3;
  localparam int MAXP_W     = 11;
  localparam int FLAG_W     = 4;
  localparam int RUN_W      = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;
  localparam int NPAGES_W   = 11;

  // offset bits that can land inside the table
  localparam int OFF_W  = PAGE_SHIFT + PAGE_IDX_W;
  localparam int END_W  = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;
  localparam int LAST_W = END_W - PAGE_SHIFT + 1;
  localparam int LIM_W  = ((PAGE_CNT_W > MAXP_W) ? PAGE_CNT_W : MAXP_W) + 2;
  localparam int SIZE_W = PAGE_SHIFT + PAGE_CNT_W;
  localparam int SAT_W  = (SIZE_W > RUN_W) ? SIZE_W : RUN_W;

  localparam logic [RUN_W-1:0] RUN_BYTES_MAX = '1;

  localparam logic [1:0] OP_FILL  = 2'd0;
  localparam logic [1:0] OP_QFLAG = 2'd1;
  localparam logic [1:0] OP_QRUN  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PAGES = 1'd1;

  // page flags: bit0 mapped, bit1 read, bit2 write, bit3 execute
  function automatic logic [FLAG_W-1:0] elf_to_flags(input logic [SEG_W-1:0] seg);
    return {seg[0], seg[1], seg[2], 1'b1};
  endfunction

endpackage

@@ sv/ppt_flag_ram.sv @@
module ppt_flag_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/page_permission_table_core.sv @@
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_stall   | opcode, address, length_bytes,
//         |           |                       | segment_flags, max_pages
// out     | out       | out_valid / out_stall | page_flags, run_bytes, outside
// cfg     | in        | cfg_write             | cfg_index, cfg_data
//
// Flag query: S_OFFSET, S_DECODE, S_LOOKUP, S_RESULT, then the output register;
// outside query skips S_LOOKUP; run query adds S_RUN, comparing pages while
// they match, as the flag RAM read port walks one entry a cycle. Fill: S_OFFSET,
// S_DECODE, S_FILL writing each page. Queries leave S_RESULT for S_IDLE.
// After reset a clearing pass writes zero to all MAX_PAGES entries, one a cycle,
// with in_stall high; cfg writes are taken throughout.
// One transaction is in flight at a time; a finished result waits in the
// output register while the next transaction is accepted.
module page_permission_table_core
  import ppt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [ADDR_W-1:0]     address,
  input  logic [LEN_W-1:0]      length_bytes,
  input  logic [SEG_W-1:0]      segment_flags,
  input  logic [MAXP_W-1:0]     max_pages,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FLAG_W-1:0]     page_flags,
  output logic [RUN_W-1:0]      run_bytes,
  output logic                  outside,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_OFFSET, S_DECODE, S_FILL, S_LOOKUP, S_RUN, S_RESULT
  } state_t;

  state_t                  state;
  logic [ADDR_W-1:0]       image_base;
  logic [NPAGES_W-1:0]     image_pages;
  logic [1:0]              op_q;
  logic [ADDR_W-1:0]       addr_q;
  logic [LEN_W-1:0]        len_q;
  logic [SEG_W-1:0]        seg_q;
  logic [MAXP_W-1:0]       maxp_q;
  logic [ADDR_W-1:0]       off;
  logic [PAGE_CNT_W-1:0]   idx;
  logic [PAGE_CNT_W-1:0]   limit;
  logic                    pend;
  logic [FLAG_W-1:0]       fill_flags;
  logic [SIZE_W-1:0]       size;
  logic [FLAG_W-1:0]       res_flags;
  logic [RUN_W-1:0]        res_size;
  logic                    res_outside;

  logic                    mem_we;
  logic [PAGE_IDX_W-1:0]   mem_waddr;
  logic [FLAG_W-1:0]       mem_wdata;
  logic                    mem_re;
  logic [PAGE_IDX_W-1:0]   mem_raddr;
  logic [FLAG_W-1:0]       mem_rdata;

  logic [LIM_W-1:0]        pages_ext;
  logic [PAGE_CNT_W-1:0]   npages;
  logic                    off_hi_nz;
  logic [PAGE_CNT_W-1:0]   page_cnt;
  logic [END_W-1:0]        end_sum;
  logic [LAST_W-1:0]       last_raw;
  logic [PAGE_CNT_W-1:0]   last_clip;
  logic                    q_outside;
  logic [LIM_W-1:0]        lim_sum;
  logic [PAGE_CNT_W-1:0]   run_limit;
  logic [SIZE_W-1:0]       first_size;
  logic                    more;
  logic                    match;
  logic                    stop;
  logic                    issue;
  logic [SIZE_W-1:0]       size_add;
  logic [RUN_W-1:0]        size_sat;
  logic                    out_free;

  ppt_flag_ram #(
    .DEPTH (MAX_PAGES),
    .WIDTH (FLAG_W),
    .AW    (PAGE_IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    pages_ext = LIM_W'(image_pages);
    npages    = (pages_ext > LIM_W'(MAX_PAGES)) ? PAGE_CNT_W'(MAX_PAGES)
                                                 : PAGE_CNT_W'(pages_ext);
    off_hi_nz = |off[ADDR_W-1:OFF_W];
    page_cnt  = {1'b0, off[OFF_W-1:PAGE_SHIFT]};

    end_sum   = END_W'(off[OFF_W-1:0]) + END_W'(len_q);
    last_raw  = LAST_W'(end_sum[END_W-1:PAGE_SHIFT])
              + LAST_W'(|end_sum[PAGE_SHIFT-1:0]);
    last_clip = (last_raw > LAST_W'(MAX_PAGES)) ? PAGE_CNT_W'(MAX_PAGES)
                                                : PAGE_CNT_W'(last_raw);

    q_outside = off_hi_nz || (page_cnt >= npages);
    lim_sum   = LIM_W'(page_cnt) + LIM_W'(1) + LIM_W'(maxp_q);
    run_limit = (lim_sum > LIM_W'(npages)) ? npages : PAGE_CNT_W'(lim_sum);
    first_size = SIZE_W'(PAGE_SIZE) - SIZE_W'(off[PAGE_SHIFT-1:0]);

    more     = (idx < limit);
    match    = (mem_rdata == res_flags);
    stop     = pend && !match;
    issue    = !stop && more;
    size_add = size + ((pend && match) ? SIZE_W'(PAGE_SIZE) : SIZE_W'(0));
    size_sat = (SAT_W'(size_add) > SAT_W'(RUN_BYTES_MAX)) ? RUN_BYTES_MAX
                                                          : RUN_W'(size_add);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[PAGE_IDX_W-1:0];
    mem_wdata = fill_flags;
    mem_re    = 1'b0;
    mem_raddr = idx[PAGE_IDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
      end
      S_FILL: begin
        mem_we = more;
      end
      S_DECODE: begin
        mem_re    = (op_q != OP_FILL) && !q_outside;
        mem_raddr = off[OFF_W-1:PAGE_SHIFT];
      end
      S_RUN: begin
        mem_re = issue;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      pend        <= 1'b0;
      out_valid   <= 1'b0;
      image_base  <= '0;
      image_pages <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_IMAGE_BASE:  image_base  <= {cfg_data[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
          REG_IMAGE_PAGES: image_pages <= cfg_data[NPAGES_W-1:0];
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          idx <= idx + PAGE_CNT_W'(1);
          if (idx == PAGE_CNT_W'(MAX_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q   <= opcode;
            addr_q <= address;
            len_q  <= length_bytes;
            seg_q  <= segment_flags;
            maxp_q <= max_pages;
            if (opcode != OP_RSVD) begin
              state <= S_OFFSET;
            end
          end
        end
        S_OFFSET: begin
          off   <= addr_q - image_base;
          state <= S_DECODE;
        end
        S_DECODE: begin
          if (op_q == OP_FILL) begin
            idx        <= page_cnt;
            limit      <= last_clip;
            fill_flags <= elf_to_flags(seg_q);
            state      <= off_hi_nz ? S_IDLE : S_FILL;
          end else if (q_outside) begin
            res_flags   <= '0;
            res_size    <= '0;
            res_outside <= 1'b1;
            state       <= S_RESULT;
          end else begin
            res_outside <= 1'b0;
            idx         <= page_cnt + PAGE_CNT_W'(1);
            limit       <= run_limit;
            size        <= first_size;
            pend        <= 1'b0;
            state       <= S_LOOKUP;
          end
        end
        S_FILL: begin
          if (more) begin
            idx <= idx + PAGE_CNT_W'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        S_LOOKUP: begin
          res_flags <= mem_rdata;
          if (op_q == OP_QFLAG) begin
            res_size <= '0;
            state    <= S_RESULT;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          size <= size_add;
          pend <= issue;
          if (issue) begin
            idx <= idx + PAGE_CNT_W'(1);
          end else begin
            res_size <= size_sat;
            state    <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            page_flags <= res_flags;
            run_bytes  <= res_size;
            outside    <= res_outside;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/ppt_checker.sv @@
module ppt_checker
  import ppt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [FLAG_W-1:0] page_flags,
  input logic [RUN_W-1:0]  run_bytes,
  input logic              outside
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(page_flags) &&
      $stable(run_bytes) && $stable(outside))
    else $error("stalled result changed");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside |-> page_flags == '0 && run_bytes == '0)
    else $error("outside result carries flags or size");

  a_mapped: assert property (@(posedge clk) disable iff (rst)
    out_valid && page_flags != '0 |-> page_flags[0])
    else $error("flags set without mapped bit");

  a_clear_stall: assert property (@(posedge clk)
    !rst && $past(rst) |-> in_stall && !out_valid)
    else $error("input taken during clearing pass");

endmodule

bind page_permission_table_core ppt_checker u_ppt_checker (.*);
